### rtl/wte_pkg.sv
package wte_pkg;

  localparam int NumSym     = 162;
  localparam int SymPerWord = 27;
  localparam int NumWord    = 6;
  localparam int WordW      = 2 * SymPerWord;
  localparam int PayloadW   = 50;
  localparam int CodeLen    = 81;
  localparam int PolyW      = 32;

  localparam logic [PolyW-1:0] PolyA = 32'hf2d05351;
  localparam logic [PolyW-1:0] PolyB = 32'he4613c47;

  // Sync vector, index 0 on the left.
  localparam logic [0:NumSym-1] SyncBits = {
    24'b110000001000111000100101,
    24'b111000000010010100000010,
    24'b110011010001101000011010,
    24'b101010010010110001101010,
    24'b001000001001001110110011,
    24'b010001110000010100110000,
    18'b000110101100011000
  };

  // Checked and coded message fields.
  typedef struct packed {
    logic       ok;
    logic [5:0] c0;
    logic [5:0] c1;
    logic [3:0] c2;
    logic [4:0] t3;
    logic [4:0] t4;
    logic [4:0] t5;
    logic [4:0] g0;
    logic [4:0] g1;
    logic [3:0] g2;
    logic [3:0] g3;
    logic [7:0] dbm;
  } chk_t;

  // Partial products of the callsign and the grid/power word.
  typedef struct packed {
    logic        ok;
    logic [13:0] call_head;
    logic [14:0] call_tail;
    logic [21:0] grid_power;
  } part_t;

  typedef struct packed {
    logic                ok;
    logic [PayloadW-1:0] payload;
  } pack_t;

endpackage

### rtl/wte_msg_if.sv
interface wte_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] call_char0;
  logic [7:0] call_char1;
  logic [7:0] call_char2;
  logic [7:0] call_char3;
  logic [7:0] call_char4;
  logic [7:0] call_char5;
  logic [2:0] call_length;
  logic [7:0] grid_char0;
  logic [7:0] grid_char1;
  logic [7:0] grid_char2;
  logic [7:0] grid_char3;
  logic [7:0] power_dbm;

  modport source (
    output valid, call_char0, call_char1, call_char2, call_char3, call_char4, call_char5,
    output call_length, grid_char0, grid_char1, grid_char2, grid_char3, power_dbm,
    input  ready
  );

  modport sink (
    input  valid, call_char0, call_char1, call_char2, call_char3, call_char4, call_char5,
    input  call_length, grid_char0, grid_char1, grid_char2, grid_char3, power_dbm,
    output ready
  );
endinterface

### rtl/wte_sym_if.sv
interface wte_sym_if;
  logic        valid;
  logic        ready;
  logic        message_valid;
  logic [53:0] symbols_0;
  logic [53:0] symbols_1;
  logic [53:0] symbols_2;
  logic [53:0] symbols_3;
  logic [53:0] symbols_4;
  logic [53:0] symbols_5;

  modport source (
    output valid, message_valid,
    output symbols_0, symbols_1, symbols_2, symbols_3, symbols_4, symbols_5,
    input  ready
  );

  modport sink (
    input  valid, message_valid,
    input  symbols_0, symbols_1, symbols_2, symbols_3, symbols_4, symbols_5,
    output ready
  );
endinterface

### rtl/wte_check.sv
module wte_check (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    call_char0,
  input  logic [7:0]    call_char1,
  input  logic [7:0]    call_char2,
  input  logic [7:0]    call_char3,
  input  logic [7:0]    call_char4,
  input  logic [7:0]    call_char5,
  input  logic [2:0]    call_length,
  input  logic [7:0]    grid_char0,
  input  logic [7:0]    grid_char1,
  input  logic [7:0]    grid_char2,
  input  logic [7:0]    grid_char3,
  input  logic [7:0]    power_dbm,
  output logic          out_valid,
  input  logic          out_ready,
  output wte_pkg::chk_t out_data
);

  localparam logic [7:0] Space = 8'd32;

  function automatic logic is_letter(input logic [7:0] c);
    return c >= 8'd65 && c <= 8'd90;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'd48 && c <= 8'd57;
  endfunction

  function automatic logic [5:0] char_code(input logic [7:0] c);
    logic [5:0] code;
    if (is_digit(c)) begin
      code = 6'(c - 8'd48);
    end else if (is_letter(c)) begin
      code = 6'(c - 8'd55);
    end else begin
      code = 6'd36;
    end
    return code;
  endfunction

  // Letters 0..25, space 26.
  function automatic logic [4:0] tail_code(input logic [7:0] c);
    return is_letter(c) ? 5'(c - 8'd65) : 5'd26;
  endfunction

  function automatic logic power_listed(input logic [7:0] p);
    logic hit;
    case (p)
      8'd0, 8'd3, 8'd7, 8'd10, 8'd13, 8'd17, 8'd20, 8'd23, 8'd27, 8'd30,
      8'd33, 8'd37, 8'd40, 8'd43, 8'd47, 8'd50, 8'd53, 8'd57, 8'd60: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  logic [7:0]    ch [6];
  logic [7:0]    pad [6];
  logic          shift;
  logic          len_ok;
  logic          call_ok;
  logic          pad_ok;
  logic          grid_ok;
  wte_pkg::chk_t chk;

  always_comb begin
    ch[0] = call_char0;
    ch[1] = call_char1;
    ch[2] = call_char2;
    ch[3] = call_char3;
    ch[4] = call_char4;
    ch[5] = call_char5;

    // Without a digit in the third place, slide right behind a space.
    shift  = !is_digit(call_char2);
    len_ok = call_length >= 3'd3 && call_length <= 3'd6 &&
             (!shift || call_length <= 3'd5);

    for (int p = 0; p < 6; p++) begin
      pad[p] = (!shift && 3'(p) < call_length) ? ch[p] : Space;
    end
    if (shift) begin
      pad[0] = Space;
      for (int p = 1; p < 6; p++) begin
        pad[p] = (3'(p - 1) < call_length) ? ch[p-1] : Space;
      end
    end

    call_ok = 1'b1;
    for (int i = 0; i < 6; i++) begin
      if (3'(i) < call_length && !(is_letter(ch[i]) || is_digit(ch[i]))) call_ok = 1'b0;
    end

    pad_ok = (is_letter(pad[0]) || is_digit(pad[0]) || pad[0] == Space) &&
             (is_letter(pad[1]) || is_digit(pad[1])) &&
             is_digit(pad[2]) && is_letter(pad[3]) &&
             (is_letter(pad[4]) || pad[4] == Space) &&
             (is_letter(pad[5]) || pad[5] == Space);

    grid_ok = grid_char0 >= 8'd65 && grid_char0 <= 8'd82 &&
              grid_char1 >= 8'd65 && grid_char1 <= 8'd82 &&
              is_digit(grid_char2) && is_digit(grid_char3);

    chk.ok  = len_ok && call_ok && pad_ok && grid_ok && power_listed(power_dbm);
    chk.c0  = char_code(pad[0]);
    chk.c1  = char_code(pad[1]);
    chk.c2  = 4'(pad[2] - 8'd48);
    chk.t3  = tail_code(pad[3]);
    chk.t4  = tail_code(pad[4]);
    chk.t5  = tail_code(pad[5]);
    chk.g0  = 5'(grid_char0 - 8'd65);
    chk.g1  = 5'(grid_char1 - 8'd65);
    chk.g2  = 4'(grid_char2 - 8'd48);
    chk.g3  = 4'(grid_char3 - 8'd48);
    chk.dbm = power_dbm;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= chk;
    end
  end

endmodule

### rtl/wte_pack.sv
module wte_pack (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  wte_pkg::chk_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output wte_pkg::pack_t out_data
);

  wte_pkg::part_t part;
  wte_pkg::part_t part_next;
  logic           part_valid;
  logic           part_ready;
  logic [7:0]     lat_term;
  logic [14:0]    grid_hi;
  logic [7:0]     power_term;
  logic [27:0]    call_word;

  // First stage: callsign head/tail and the grid/power word.
  always_comb begin
    part_next.ok        = in_data.ok;
    part_next.call_head = (14'(in_data.c0) * 14'd36 + 14'(in_data.c1)) * 14'd10
                          + 14'(in_data.c2);
    part_next.call_tail = (15'(in_data.t3) * 15'd27 + 15'(in_data.t4)) * 15'd27
                          + 15'(in_data.t5);
    lat_term   = 8'd179 - 8'd10 * 8'(in_data.g0) - 8'(in_data.g2);
    grid_hi    = 15'(lat_term) * 15'd180 + 15'd10 * 15'(in_data.g1) + 15'(in_data.g3);
    power_term = in_data.dbm + 8'd64;
    part_next.grid_power = {grid_hi, power_term[6:0]};
  end

  assign part_ready = !out_valid || out_ready;
  assign in_ready   = !part_valid || part_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      part_valid <= 1'b0;
    end else if (in_ready) begin
      part_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      part <= part_next;
    end
  end

  // Second stage: head times 27^3 plus the three tail places.
  assign call_word = 28'(part.call_head) * 28'd19683 + 28'(part.call_tail);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (part_ready) begin
      out_valid <= part_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (part_ready && part_valid) begin
      out_data.ok      <= part.ok;
      out_data.payload <= {call_word, part.grid_power};
    end
  end

endmodule

### rtl/wte_code.sv
module wte_code (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  wte_pkg::pack_t                       in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 message_valid,
  output logic [2*wte_pkg::NumSym-1:0]         symbols
);

  // Each coded bit is an XOR over the payload bits its generator taps see.
  function automatic logic [2*wte_pkg::CodeLen-1:0] conv_encode(
    input logic [wte_pkg::PayloadW-1:0] payload
  );
    logic [2*wte_pkg::CodeLen-1:0] coded;
    coded = '0;
    for (int i = 0; i < wte_pkg::CodeLen; i++) begin
      for (int k = 0; k < wte_pkg::PolyW; k++) begin
        if (k <= i && i - k < wte_pkg::PayloadW) begin
          if (wte_pkg::PolyA[k]) begin
            coded[2*i] = coded[2*i] ^ payload[wte_pkg::PayloadW-1-(i-k)];
          end
          if (wte_pkg::PolyB[k]) begin
            coded[2*i+1] = coded[2*i+1] ^ payload[wte_pkg::PayloadW-1-(i-k)];
          end
        end
      end
    end
    return coded;
  endfunction

  // Bit-reversed address order; pure wiring.
  function automatic logic [wte_pkg::NumSym-1:0] interleave(
    input logic [wte_pkg::NumSym-1:0] coded
  );
    logic [wte_pkg::NumSym-1:0] data;
    logic [7:0]                 rev;
    int                         src;
    data = '0;
    src  = 0;
    for (int i = 0; i < 256; i++) begin
      for (int k = 0; k < 8; k++) begin
        rev[7-k] = i[k];
      end
      if (32'(rev) < wte_pkg::NumSym) begin
        data[rev] = coded[src];
        src++;
      end
    end
    return data;
  endfunction

  logic [wte_pkg::NumSym-1:0]   data_bits;
  logic [2*wte_pkg::NumSym-1:0] symbols_next;

  always_comb begin
    data_bits = interleave(conv_encode(in_data.payload));
    for (int r = 0; r < wte_pkg::NumSym; r++) begin
      symbols_next[2*r +: 2] = in_data.ok ? {data_bits[r], wte_pkg::SyncBits[r]} : 2'b00;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      message_valid <= in_data.ok;
      symbols       <= symbols_next;
    end
  end

endmodule

### rtl/wspr_type1_message_encoder_unit.sv
// WSPR type 1 message encoder.
// Input channel msg: a callsign of up to six ASCII bytes with its length, a
// four-character grid locator and a power in dBm, one message per beat.
// Output channel sym: message_valid and 162 two-bit channel symbols packed 27
// to a 54-bit word, symbol t of a word at bits 2t+1..2t. A message that fails
// its checks comes out with message_valid low and all words zero.
// Four register stages: field check and character coding, callsign and grid
// packing, the 27^3 multiply that completes the 50-bit payload, and the
// convolutional code with interleave and sync into the output register.
// One message per cycle sustained while sym is ready; every stage is
// combinational logic feeding its register, so nothing iterates.
// Each stage has its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up: while sym is stalled msg keeps
// accepting until all four stages hold a beat, and nothing is dropped.
// Reset clears every valid bit; the pipeline starts empty and msg is ready
// in the first cycle after reset.
module wspr_type1_message_encoder_unit (
  input logic       clk,
  input logic       rst,
  wte_msg_if.sink   msg,
  wte_sym_if.source sym
);

  wte_pkg::chk_t                chk_data;
  logic                         chk_valid;
  logic                         chk_ready;
  wte_pkg::pack_t               pack_data;
  logic                         pack_valid;
  logic                         pack_ready;
  logic [2*wte_pkg::NumSym-1:0] symbols;

  wte_check u_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (msg.valid),
    .in_ready    (msg.ready),
    .call_char0  (msg.call_char0),
    .call_char1  (msg.call_char1),
    .call_char2  (msg.call_char2),
    .call_char3  (msg.call_char3),
    .call_char4  (msg.call_char4),
    .call_char5  (msg.call_char5),
    .call_length (msg.call_length),
    .grid_char0  (msg.grid_char0),
    .grid_char1  (msg.grid_char1),
    .grid_char2  (msg.grid_char2),
    .grid_char3  (msg.grid_char3),
    .power_dbm   (msg.power_dbm),
    .out_valid   (chk_valid),
    .out_ready   (chk_ready),
    .out_data    (chk_data)
  );

  wte_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chk_valid),
    .in_ready  (chk_ready),
    .in_data   (chk_data),
    .out_valid (pack_valid),
    .out_ready (pack_ready),
    .out_data  (pack_data)
  );

  wte_code u_code (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (pack_valid),
    .in_ready      (pack_ready),
    .in_data       (pack_data),
    .out_valid     (sym.valid),
    .out_ready     (sym.ready),
    .message_valid (sym.message_valid),
    .symbols       (symbols)
  );

  assign sym.symbols_0 = symbols[0*wte_pkg::WordW +: wte_pkg::WordW];
  assign sym.symbols_1 = symbols[1*wte_pkg::WordW +: wte_pkg::WordW];
  assign sym.symbols_2 = symbols[2*wte_pkg::WordW +: wte_pkg::WordW];
  assign sym.symbols_3 = symbols[3*wte_pkg::WordW +: wte_pkg::WordW];
  assign sym.symbols_4 = symbols[4*wte_pkg::WordW +: wte_pkg::WordW];
  assign sym.symbols_5 = symbols[5*wte_pkg::WordW +: wte_pkg::WordW];

  // An empty output stage lets the whole chain advance.
  a_ready_when_out_empty: assert property (
    @(posedge clk) disable iff (rst) !sym.valid |-> msg.ready
  ) else $error("msg not ready while output stage is empty");

  a_accept_fills_first_stage: assert property (
    @(posedge clk) disable iff (rst) msg.valid && msg.ready |=> chk_valid
  ) else $error("accepted beat did not reach the check stage");

  a_invalid_is_zero: assert property (
    @(posedge clk) disable iff (rst)
    sym.valid && !sym.message_valid |->
      sym.symbols_0 == 54'd0 && sym.symbols_1 == 54'd0 && sym.symbols_2 == 54'd0 &&
      sym.symbols_3 == 54'd0 && sym.symbols_4 == 54'd0 && sym.symbols_5 == 54'd0
  ) else $error("rejected message carries nonzero symbols");

  a_sync_first_symbol: assert property (
    @(posedge clk) disable iff (rst)
    sym.valid && sym.message_valid |-> sym.symbols_0[0] == wte_pkg::SyncBits[0]
  ) else $error("sync bit of symbol 0 wrong");

endmodule
